@@ hdl/wts_pkg.sv @@
// Package: shared types and constants for the windowed trend slope unit.
package wts_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned SlopeWidth  = 18;
  localparam int unsigned FilledWidth = 9;

  typedef logic [SampleWidth-1:0]        sample_t;
  typedef logic signed [SlopeWidth-1:0]  slope_t;
  typedef logic [FilledWidth-1:0]        filled_t;

endpackage

@@ hdl/wts_if.sv @@
// Interfaces: valid/ready channels for samples and slope results.
interface wts_in_if;
  logic              valid;
  logic              ready;
  wts_pkg::sample_t  sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wts_out_if;
  logic              valid;
  logic              ready;
  wts_pkg::slope_t   slope;
  wts_pkg::filled_t  filled;
  modport source (output valid, output slope, output filled, input ready);
  modport sink   (input valid, input slope, input filled, output ready);
endinterface

@@ hdl/windowed_trend_slope_unit.sv @@
// Top level: sliding-window least-squares slope over a circular sample history.
//
// Each accepted sample is written into a history RAM of HistoryDepth entries
// and one result (slope, filled) is returned per transaction. The slope is
// the integer least-squares quotient (n*Sxy - Sx*Sy) / (n*Sxx - Sx*Sx)
// on raw sample codes, position 0 being the oldest stored sample, truncated
// toward zero, saturated to a magnitude of 65536 and given as signed Q17.0;
// it is zero below two samples. Each item passes through the accept, an
// accumulation pass (one RAM read per cycle, registered read data, a step
// to close the pass), the forming of numerator and denominator, the
// restoring divider (a quotient of DivBits = 3*CntW + 18 bits, 33 at the
// default depth) and the load of the output register. Items are handled one
// at a time; the input is ready again as soon as the result has moved into
// the output register, so a held result does not block intake of the next
// sample, it only delays the load of the following result. No clearing
// pass is needed after reset.
module windowed_trend_slope_unit #(
  parameter int unsigned HistoryDepth = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wts_in_if.sink     in_i,
  wts_out_if.source  out_o
);

  localparam int unsigned AddrW  = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int unsigned CntW   = $clog2(HistoryDepth + 1);
  // Sums: Sy < n*2^16, Sxy < n^2*2^16, Sxx < n^3.
  localparam int unsigned SumW   = 2*CntW + 17;
  // num = n*Sxy - Sx*Sy bounded by n^3 * 2^16.
  localparam int unsigned NumW   = 3*CntW + 18;
  localparam int unsigned DivBits = NumW;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StAcc   = 5'b00010,
    StForm  = 5'b00100,
    StDiv   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // History RAM, synchronous read.
  wts_pkg::sample_t mem [HistoryDepth];
  wts_pkg::sample_t rd_data_q;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;

  logic [AddrW-1:0] wslot_q;
  logic [CntW-1:0]  fill_q;
  logic [AddrW-1:0] raddr_q;    // next read address
  logic [CntW-1:0]  issue_q;    // reads issued
  logic [CntW-1:0]  xcnt_q;     // x of data arriving
  logic             rvalid_q;

  logic [SumW-1:0]  sy_q, sxy_q, sxx_q, sx_q;
  logic [NumW-1:0]  nabs_q, den_q, rem_q, quo_q;
  logic             neg_q;
  logic [$clog2(DivBits+1)-1:0] step_q;

  logic                  ovalid_q;
  wts_pkg::slope_t       oslope_q;
  wts_pkg::filled_t      ofilled_q;

  logic accept;
  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == StIdle);
  assign wr_en    = accept;
  assign rd_addr  = raddr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wslot_q] <= in_i.sample;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Signed intermediate products for num/den formation.
  logic signed [NumW+1:0] num_s, den_s;
  logic [NumW-1:0]        n_ext;
  assign n_ext = NumW'(fill_q);
  always_comb begin
    num_s = $signed({2'b00, n_ext * NumW'(sxy_q)}) -
            $signed({2'b00, NumW'(sx_q) * NumW'(sy_q)});
    den_s = $signed({2'b00, n_ext * NumW'(sxx_q)}) -
            $signed({2'b00, NumW'(sx_q) * NumW'(sx_q)});
  end

  logic [NumW:0] trial;
  assign trial = {rem_q, nabs_q[NumW-1]} - {1'b0, den_q};

  // saturate magnitude to 65536
  logic [NumW-1:0] mag;
  assign mag = (quo_q > NumW'(65536)) ? NumW'(65536) : quo_q;

  logic out_free;
  assign out_free = !ovalid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept) state_d = StAcc;
      StAcc:  if (!rvalid_q && issue_q == fill_q) state_d = StForm;
      StForm: state_d = StDiv;
      StDiv:  if (step_q == '0) state_d = StOut;
      StOut:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      wslot_q  <= '0;
      fill_q   <= '0;
      ovalid_q <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        wslot_q <= (wslot_q == AddrW'(HistoryDepth-1)) ? '0 : wslot_q + 1'b1;
        if (fill_q != CntW'(HistoryDepth)) fill_q <= fill_q + 1'b1;
      end
      rvalid_q <= (state_q == StAcc) && (issue_q != fill_q);
      if (state_q == StOut && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Datapath (no reset needed).
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        // oldest = slot + 1 - n, mod depth, after this write
        raddr_q <= (fill_q == CntW'(HistoryDepth)) ? 
                   ((wslot_q == AddrW'(HistoryDepth-1)) ? '0 : wslot_q + 1'b1) : '0;
        issue_q <= '0;
        xcnt_q  <= '0;
        sx_q <= '0; sy_q <= '0; sxy_q <= '0; sxx_q <= '0;
      end
      StAcc: begin
        if (issue_q != fill_q) begin
          issue_q <= issue_q + 1'b1;
          raddr_q <= (raddr_q == AddrW'(HistoryDepth-1)) ? '0 : raddr_q + 1'b1;
        end
        if (rvalid_q) begin
          sx_q  <= sx_q + SumW'(xcnt_q);
          sy_q  <= sy_q + SumW'(rd_data_q);
          sxy_q <= sxy_q + SumW'(xcnt_q) * SumW'(rd_data_q);
          sxx_q <= sxx_q + SumW'(xcnt_q) * SumW'(xcnt_q);
          xcnt_q <= xcnt_q + 1'b1;
        end
      end
      StForm: begin
        neg_q  <= num_s[NumW+1];
        nabs_q <= num_s[NumW+1] ? NumW'(-num_s) : NumW'(num_s);
        den_q  <= NumW'(den_s);
        rem_q  <= '0;
        quo_q  <= '0;
        step_q <= ($bits(step_q))'(DivBits);
      end
      StDiv: begin
        if (step_q != '0) begin
          step_q <= step_q - 1'b1;
          nabs_q <= {nabs_q[NumW-2:0], 1'b0};
          if (!trial[NumW]) begin
            rem_q <= trial[NumW-1:0];
            quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[NumW-2:0], nabs_q[NumW-1]};
            quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
        end
      end
      StOut: begin
        if (out_free) begin
          ofilled_q <= wts_pkg::filled_t'(fill_q);
          if (fill_q < CntW'(2) || den_q == '0) begin
            oslope_q <= '0;
          end else begin
            oslope_q <= neg_q ? -wts_pkg::slope_t'(mag)
                              :  wts_pkg::slope_t'(mag);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid  = ovalid_q;
  assign out_o.slope  = oslope_q;
  assign out_o.filled = ofilled_q;

endmodule
